### sv/assert_macros.svh
// Assertion macros for the batch packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define DBPRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DBPRR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/dbprr_pkg.sv
// Shared types and constants of the round-robin batch packer.
`default_nettype none

package dbprr_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KindBatch = 2'd0,
    KindError = 2'd1,
    KindDone  = 2'd2
  } item_kind_e;

  // Configuration register indexes.
  localparam logic [1:0] RegMaxBatchCost    = 2'd0;
  localparam logic [1:0] RegPartitionCount  = 2'd1;
  localparam logic [1:0] RegPartitionNumber = 2'd2;
  localparam logic [1:0] RegAllowPartial    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [31:0] MaxBatchCostReset   = 32'd4096;
  localparam logic [10:0] PartitionCountReset = 11'd1;

  // Most results one sample can cause.
  localparam int ResultSlots = 3;

  // One result item.
  typedef struct packed {
    item_kind_e  kind;
    logic [31:0] start;
    logic [31:0] count;
  } result_t;

  // Write of one sample's results into the output buffer.
  typedef struct packed {
    logic       valid;
    logic [1:0] cnt;
  } buf_wr_t;

endpackage

`default_nettype wire

### sv/dynamic_batch_packer_round_robin_top.sv
// A sample is registered in the input register, then its results in the output buffer.
// One sample per cycle while the output buffer is free; k results hold it until all are taken.
// The per-sample path is one max, one 32x16 multiply and a compare into the run state.
// Samples that cause no result pass even while the output buffer is full.
// Reset loads the configuration defaults and clears the run state and both buffers.
`default_nettype none

module dynamic_batch_packer_round_robin_top #(
  parameter int IndexWidth    = 32,
  parameter int MaxPartitions = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Sample stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_length
  input  wire logic        s_axis_tlast,   // final_sample
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [31:0] batch_start, [63:32] batch_count
  output logic [1:0]       m_axis_tuser,   // [1:0] item_kind
  output logic             m_axis_tlast    // last_of_step
);

  localparam int SumW = (IndexWidth + 1 > 33) ? IndexWidth + 1 : 33;
  localparam logic [31:0] MaxPartW = 32'(MaxPartitions);

  typedef struct packed {
    logic [10:0]           rp;
    logic                  hv;
    logic [IndexWidth-1:0] hs;
    logic [IndexWidth-1:0] hl;
    logic                  emit;
  } round_t;

  // Close one batch: take it if it falls in this slot, emit the held batch at round end.
  function automatic round_t close_batch(round_t cur, logic [IndexWidth-1:0] start,
                                         logic [IndexWidth-1:0] blen, logic [10:0] eff,
                                         logic [9:0] pnum);
    round_t     r;
    logic [11:0] inc;
    r      = cur;
    r.emit = 1'b0;
    if (r.rp == {1'b0, pnum}) begin
      r.hv = 1'b1;
      r.hs = start;
      r.hl = blen;
    end
    inc = {1'b0, r.rp} + 12'd1;
    if (inc >= {1'b0, eff}) begin
      r.emit = r.hv;
      r.hv   = 1'b0;
      r.rp   = 11'd0;
    end else begin
      r.rp = inc[10:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [31:0] cost_q;
  logic [10:0] pcount_q;
  logic [9:0]  pnum_q;
  logic        partial_q;

  // Input register.
  logic        in_valid_q;
  logic [15:0] len_q;
  logic        fin_q;

  // Run state.
  logic [IndexWidth-1:0] cnt_q, cnt_d;
  logic [IndexWidth-1:0] open_start_q, open_start_d;
  logic [IndexWidth-1:0] open_len_q, open_len_d;
  logic [15:0]           open_max_q, open_max_d;
  logic [10:0]           round_pos_q, round_pos_d;
  logic                  held_valid_q, held_valid_d;
  logic [IndexWidth-1:0] held_start_q, held_start_d;
  logic [IndexWidth-1:0] held_len_q, held_len_d;
  logic                  errored_q, errored_d;

  // Per-sample datapath.
  logic [10:0]           eff_count;
  logic                  oversize;
  logic [15:0]           nmax;
  logic [SumW-1:0]       sum_ext;
  logic                  over_cnt;
  logic [47:0]           prod;
  logic                  exceed;
  logic [IndexWidth-1:0] ns, nl;
  logic [15:0]           nm;
  round_t                r_cur, r_a, r_b;
  logic                  emit_b;
  logic [1:0]            n_res;
  dbprr_pkg::result_t [dbprr_pkg::ResultSlots-1:0] res;
  logic                  advance;
  logic                  buf_free;
  dbprr_pkg::buf_wr_t    buf_wr;
  dbprr_pkg::result_t    out_res;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q    <= dbprr_pkg::MaxBatchCostReset;
      pcount_q  <= dbprr_pkg::PartitionCountReset;
      pnum_q    <= 10'd0;
      partial_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbprr_pkg::RegMaxBatchCost:    cost_q    <= cfg_data_i;
        dbprr_pkg::RegPartitionCount:  pcount_q  <= cfg_data_i[10:0];
        dbprr_pkg::RegPartitionNumber: pnum_q    <= cfg_data_i[9:0];
        dbprr_pkg::RegAllowPartial:    partial_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective partition count: zero counts as one, clamp at the partition limit.
  always_comb begin
    if (pcount_q == 11'd0) begin
      eff_count = 11'd1;
    end else if (32'(pcount_q) > MaxPartW) begin
      eff_count = 11'(MaxPartitions);
    end else begin
      eff_count = pcount_q;
    end
  end

  // Batch cost test for the sample joining the open batch.
  assign oversize = (32'(len_q) > cost_q);
  assign nmax     = (len_q > open_max_q) ? len_q : open_max_q;
  assign sum_ext  = SumW'(open_len_q) + SumW'(1);
  assign over_cnt = (sum_ext > SumW'(cost_q));
  assign prod     = 48'(sum_ext[31:0]) * 48'(nmax);
  assign exceed   = (nmax != 16'd0) && (over_cnt || (prod > 48'(cost_q)));

  // Next run state and the results of the registered sample.
  always_comb begin
    cnt_d        = cnt_q;
    open_start_d = open_start_q;
    open_len_d   = open_len_q;
    open_max_d   = open_max_q;
    round_pos_d  = round_pos_q;
    held_valid_d = held_valid_q;
    held_start_d = held_start_q;
    held_len_d   = held_len_q;
    errored_d    = errored_q;
    res          = '0;
    n_res        = 2'd0;
    ns           = open_start_q;
    nl           = open_len_q;
    nm           = open_max_q;
    emit_b       = 1'b0;

    r_cur.rp   = round_pos_q;
    r_cur.hv   = held_valid_q;
    r_cur.hs   = held_start_q;
    r_cur.hl   = held_len_q;
    r_cur.emit = 1'b0;
    r_a        = r_cur;
    r_b        = r_cur;

    if (errored_q) begin
      // Rest of a failed run: drop samples up to the final one.
      if (fin_q) begin
        errored_d = 1'b0;
      end
    end else if (oversize) begin
      res[0].kind  = dbprr_pkg::KindError;
      res[0].start = 32'(cnt_q);
      res[0].count = 32'd0;
      n_res        = 2'd1;
      errored_d    = !fin_q;
    end else begin
      // Join the open batch or start a new one.
      if (open_len_q == '0) begin
        ns = cnt_q;
        nl = IndexWidth'(1);
        nm = len_q;
      end else if (exceed) begin
        r_a = close_batch(r_cur, open_start_q, open_len_q, eff_count, pnum_q);
        ns  = cnt_q;
        nl  = IndexWidth'(1);
        nm  = len_q;
      end else begin
        nl = (open_len_q != '1) ? open_len_q + IndexWidth'(1) : open_len_q;
        nm = nmax;
      end

      if (r_a.emit) begin
        res[0].kind  = dbprr_pkg::KindBatch;
        res[0].start = 32'(r_a.hs);
        res[0].count = 32'(r_a.hl);
        n_res        = 2'd1;
      end

      open_start_d = ns;
      open_len_d   = nl;
      open_max_d   = nm;
      round_pos_d  = r_a.rp;
      held_valid_d = r_a.hv;
      held_start_d = r_a.hs;
      held_len_d   = r_a.hl;
      cnt_d        = cnt_q + IndexWidth'(1);

      // Final sample: close the open batch, flush a partial round, then done.
      if (fin_q) begin
        r_b    = close_batch(r_a, ns, nl, eff_count, pnum_q);
        emit_b = r_b.emit || ((r_b.rp != 11'd0) && partial_q && r_b.hv);
        if (emit_b) begin
          res[n_res].kind  = dbprr_pkg::KindBatch;
          res[n_res].start = 32'(r_b.hs);
          res[n_res].count = 32'(r_b.hl);
          n_res            = n_res + 2'd1;
        end
        res[n_res].kind  = dbprr_pkg::KindDone;
        res[n_res].start = 32'd0;
        res[n_res].count = 32'd0;
        n_res            = n_res + 2'd1;
      end
    end

    // Any final sample ends the run.
    if (fin_q) begin
      cnt_d        = '0;
      open_start_d = '0;
      open_len_d   = '0;
      open_max_d   = 16'd0;
      round_pos_d  = 11'd0;
      held_valid_d = 1'b0;
      held_start_d = '0;
      held_len_d   = '0;
      errored_d    = 1'b0;
    end
  end

  // A sample advances when its results fit in the output buffer.
  assign advance       = in_valid_q && (buf_free || (n_res == 2'd0));
  assign s_axis_tready = !in_valid_q || advance;
  assign buf_wr.valid  = advance && (n_res != 2'd0);
  assign buf_wr.cnt    = n_res;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      len_q      <= 16'd0;
      fin_q      <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
      len_q      <= s_axis_tdata;
      fin_q      <= s_axis_tlast;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Run state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      open_start_q <= '0;
      open_len_q   <= '0;
      open_max_q   <= 16'd0;
      round_pos_q  <= 11'd0;
      held_valid_q <= 1'b0;
      held_start_q <= '0;
      held_len_q   <= '0;
      errored_q    <= 1'b0;
    end else if (advance) begin
      cnt_q        <= cnt_d;
      open_start_q <= open_start_d;
      open_len_q   <= open_len_d;
      open_max_q   <= open_max_d;
      round_pos_q  <= round_pos_d;
      held_valid_q <= held_valid_d;
      held_start_q <= held_start_d;
      held_len_q   <= held_len_d;
      errored_q    <= errored_d;
    end
  end

  // Output buffer.
  dbprr_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (buf_wr),
    .res_i       (res),
    .free_o      (buf_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_res.count, out_res.start};
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

### sv/dbprr_outbuf.sv
// Output buffer that holds the results of one sample and drains them one per cycle while out_ready_i is high.
`default_nettype none

`include "assert_macros.svh"

module dbprr_outbuf (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire dbprr_pkg::buf_wr_t                         wr_i,
  input  wire dbprr_pkg::result_t [dbprr_pkg::ResultSlots-1:0] res_i,
  output logic                                            free_o,
  output logic                                            out_valid_o,
  input  wire logic                                       out_ready_i,
  output dbprr_pkg::result_t                              out_res_o,
  output logic                                            out_last_o
);

  logic                                               occ_q;
  logic [1:0]                                         cnt_q;
  logic [1:0]                                         ptr_q;
  dbprr_pkg::result_t [dbprr_pkg::ResultSlots-1:0]    slot_q;
  logic                                               take;
  logic                                               last;

  // Current result and whether it closes the sample's group.
  assign last        = (ptr_q == (cnt_q - 2'd1));
  assign take        = occ_q && out_ready_i;
  assign free_o      = !occ_q || (take && last);
  assign out_valid_o = occ_q;
  assign out_last_o  = last;
  assign out_res_o   = slot_q[ptr_q];

  // Control: load a new group or step through the held one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      cnt_q <= 2'd0;
      ptr_q <= 2'd0;
    end else if (wr_i.valid) begin
      occ_q <= 1'b1;
      cnt_q <= wr_i.cnt;
      ptr_q <= 2'd0;
    end else if (take) begin
      if (last) begin
        occ_q <= 1'b0;
      end else begin
        ptr_q <= ptr_q + 2'd1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      slot_q <= res_i;
    end
  end

  `DBPRR_ASSERT(a_wr_only_when_free, wr_i.valid |-> free_o, "write into a busy output buffer")
  `DBPRR_ASSERT(a_wr_count_nonzero, wr_i.valid |-> (wr_i.cnt != 2'd0), "empty result group written")
  `DBPRR_ASSERT(a_ptr_in_range, occ_q |-> (ptr_q < cnt_q), "read pointer past the held results")
  `DBPRR_ASSERT(a_drain_empties, (take && last && !wr_i.valid) |=> !occ_q, "buffer still full after last transfer")

endmodule

`default_nettype wire

### tb/dbprr_checker.sv
// Checker for the batch packer: predicts results from observed transfers and compares them.
`timescale 1ns / 100ps

module dbprr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration channel, observed.
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Sample stream, observed.
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [15:0] s_data_i,     // [15:0] sample_length
  input  logic        s_last_i,     // final_sample
  // Result stream, observed.
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,     // [31:0] batch_start, [63:32] batch_count
  input  logic [1:0]  m_user_i,     // [1:0] item_kind
  input  logic        m_last_i,     // last_of_step
  // Status for the testbench top.
  output int          mismatch_o,
  output int          pending_o,
  output int          checked_o,
  output int          batches_o,
  output int          errors_o,
  output int          dones_o
);

  localparam int unsigned MaxParts = 1024;

  typedef struct packed {
    dbprr_pkg::item_kind_e kind;
    logic [31:0]           start;
    logic [31:0]           count;
    logic                  last;
  } packer_item_t;

  // Results the block still owes, oldest first.
  packer_item_t owed_items[$];

  // Results of the sample being predicted.
  packer_item_t step_buf[dbprr_pkg::ResultSlots];
  int           step_n;

  // Configuration copy.
  logic [31:0] cost_q;
  logic [10:0] part_count_q;
  logic [9:0]  part_num_q;
  logic        allow_partial_q;

  // Run state copy.
  logic [31:0] next_index;
  logic [31:0] open_start;
  logic [31:0] open_len;
  logic [15:0] open_max;
  int unsigned round_pos;
  logic        held_valid;
  logic [31:0] held_start;
  logic [31:0] held_len;
  logic        in_error;

  int bad;
  int seen;
  int n_batch;
  int n_error;
  int n_done;

  function automatic void clear_run();
    next_index = '0;
    open_start = '0;
    open_len   = '0;
    open_max   = '0;
    round_pos  = 0;
    held_valid = 1'b0;
    held_start = '0;
    held_len   = '0;
    in_error   = 1'b0;
  endfunction

  // Zero partitions act as one, and the count is capped at the supported maximum.
  function automatic int unsigned effective_count();
    if (part_count_q == 0) return 1;
    if (part_count_q > MaxParts) return MaxParts;
    return part_count_q;
  endfunction

  function automatic void note_item(dbprr_pkg::item_kind_e kind, logic [31:0] start,
                                    logic [31:0] count);
    step_buf[step_n] = '{kind, start, count, 1'b0};
    step_n++;
  endfunction

  // Deal a closed batch to the current slot and release the held one when the round is full.
  function automatic void deal_batch(logic [31:0] start, logic [31:0] len);
    int unsigned pc;
    pc = effective_count();
    if (round_pos == part_num_q) begin
      held_valid = 1'b1;
      held_start = start;
      held_len   = len;
    end
    round_pos++;
    if (round_pos >= pc) begin
      if (held_valid) note_item(dbprr_pkg::KindBatch, held_start, held_len);
      held_valid = 1'b0;
      round_pos  = 0;
    end
  endfunction

  // Greedy packing of one sample; the results it causes join the owed queue.
  task automatic pack_sample(input logic [15:0] len, input logic fin);
    logic [15:0]  peak;
    logic [63:0]  grown;
    logic         over;
    packer_item_t item;
    step_n = 0;
    if (in_error) begin
      // Everything up to the next final sample is skipped.
      if (fin) clear_run();
    end else if ({16'b0, len} > cost_q) begin
      note_item(dbprr_pkg::KindError, next_index, '0);
      if (fin) clear_run();
      else in_error = 1'b1;
    end else begin
      if (open_len == 0) begin
        open_start = next_index;
        open_len   = 32'd1;
        open_max   = len;
      end else begin
        peak  = (len > open_max) ? len : open_max;
        grown = {32'b0, open_len} + 64'd1;
        if (peak == 0) over = 1'b0;
        else if (grown > {32'b0, cost_q}) over = 1'b1;
        else over = (grown * {48'b0, peak}) > {32'b0, cost_q};
        if (over) begin
          deal_batch(open_start, open_len);
          open_start = next_index;
          open_len   = 32'd1;
          open_max   = len;
        end else begin
          if (open_len != '1) open_len = open_len + 32'd1;
          open_max = peak;
        end
      end
      next_index = next_index + 32'd1;
      if (fin) begin
        deal_batch(open_start, open_len);
        if (round_pos != 0 && allow_partial_q && held_valid) begin
          note_item(dbprr_pkg::KindBatch, held_start, held_len);
        end
        note_item(dbprr_pkg::KindDone, '0, '0);
        clear_run();
      end
    end
    for (int i = 0; i < step_n; i++) begin
      item      = step_buf[i];
      item.last = (i == step_n - 1);
      owed_items = {owed_items, item};
    end
  endtask

  // Results are compared before the same edge's sample is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q          = dbprr_pkg::MaxBatchCostReset;
      part_count_q    = dbprr_pkg::PartitionCountReset;
      part_num_q      = '0;
      allow_partial_q = 1'b0;
      clear_run();
      owed_items.delete();
      bad     = 0;
      seen    = 0;
      n_batch = 0;
      n_error = 0;
      n_done  = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin : take_result
        packer_item_t want;
        seen++;
        if (m_user_i == dbprr_pkg::KindBatch) n_batch++;
        else if (m_user_i == dbprr_pkg::KindError) n_error++;
        else if (m_user_i == dbprr_pkg::KindDone) n_done++;
        if (owed_items.size() == 0) begin
          bad++;
          if (bad <= 10) begin
            $display("[%0t] unexpected result: kind %0d start %0d count %0d last %0b",
                     $realtime, m_user_i, m_data_i[31:0], m_data_i[63:32], m_last_i);
          end
        end else begin
          want = owed_items.pop_front();
          if (want.kind !== m_user_i || want.start !== m_data_i[31:0] ||
              want.count !== m_data_i[63:32] || want.last !== m_last_i) begin
            bad++;
            if (bad <= 10) begin
              $display("[%0t] mismatch: expected kind %0d start %0d count %0d last %0b",
                       $realtime, want.kind, want.start, want.count, want.last);
              $display("           actual   kind %0d start %0d count %0d last %0b",
                       m_user_i, m_data_i[31:0], m_data_i[63:32], m_last_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          dbprr_pkg::RegMaxBatchCost:    cost_q          = cfg_data_i;
          dbprr_pkg::RegPartitionCount:  part_count_q    = cfg_data_i[10:0];
          dbprr_pkg::RegPartitionNumber: part_num_q      = cfg_data_i[9:0];
          dbprr_pkg::RegAllowPartial:    allow_partial_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) pack_sample(s_data_i, s_last_i);
    end
    mismatch_o <= bad;
    pending_o  <= owed_items.size();
    checked_o  <= seen;
    batches_o  <= n_batch;
    errors_o   <= n_error;
    dones_o    <= n_done;
  end

endmodule

### tb/tb_dynamic_batch_packer_round_robin_top.sv
// Testbench top for the round-robin batch packer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_dynamic_batch_packer_round_robin_top;

  localparam int TargetSamples = 310;
  localparam int IdleLimit     = 1000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] sample_length
  logic        s_axis_tlast;   // final_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [31:0] batch_start, [63:32] batch_count
  logic [1:0]  m_axis_tuser;   // [1:0] item_kind
  logic        m_axis_tlast;   // last_of_step

  int mismatches;
  int pending_cnt;
  int checked_cnt;
  int batch_cnt;
  int error_cnt;
  int done_cnt;

  int   samples_sent;
  int   reg_writes;
  int   phases;
  int   idle_cycles;
  logic steady;

  dynamic_batch_packer_round_robin_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  dbprr_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .m_user_i   (m_axis_tuser),
    .m_last_i   (m_axis_tlast),
    .mismatch_o (mismatches),
    .pending_o  (pending_cnt),
    .checked_o  (checked_cnt),
    .batches_o  (batch_cnt),
    .errors_o   (error_cnt),
    .dones_o    (done_cnt)
  );

  // Clock with an 8 ns period.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Idle cycles before the next transfer; steady phases run without gaps.
  function automatic int idle_draw();
    if (steady) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    reg_writes++;
  endtask

  // Offer one sample after a random gap and hold it until the transfer.
  task automatic offer_sample(input logic [15:0] len, input logic fin);
    int gap;
    gap = idle_draw();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = len;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
  endtask

  // Stop sending, let every owed result arrive, then allow for samples still in flight.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending_cnt == 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Result side: random stall before each transfer.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = idle_draw();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
                 (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed", IdleLimit,
                 pending_cnt);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Stimulus: directed cases, then random phases of settings and runs.
  initial begin
    int unsigned len_cap;
    logic [31:0] cost_now;
    logic [10:0] count_now;
    logic [9:0]  num_now;
    logic [31:0] data;
    logic [15:0] len;
    int          runs;
    int          run_len;
    logic        cut;
    int unsigned pick;

    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dbprr_pkg::RegMaxBatchCost;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    steady        = 1'b0;
    samples_sent  = 0;
    reg_writes    = 0;
    phases        = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: zero lengths, lengths at the limit, oversize with and without final.
    phases++;
    offer_sample(16'd0, 1'b0);
    offer_sample(16'd0, 1'b0);
    offer_sample(16'd4096, 1'b0);
    offer_sample(16'd4096, 1'b0);
    offer_sample(16'd1, 1'b1);
    offer_sample(16'd4097, 1'b0);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'd7, 1'b1);
    offer_sample(16'd4097, 1'b1);
    offer_sample(16'd300, 1'b1);

    // Three partitions, last slot, partial rounds kept; the full round closes at final.
    drain_results();
    phases++;
    write_reg(dbprr_pkg::RegMaxBatchCost, 32'd131070);
    write_reg(dbprr_pkg::RegPartitionCount, 32'd3);
    write_reg(dbprr_pkg::RegPartitionNumber, 32'd2);
    write_reg(dbprr_pkg::RegAllowPartial, 32'd1);
    repeat (4) offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'hFFFF, 1'b1);

    // Two partitions: a round release and a partial round on the same final sample.
    drain_results();
    phases++;
    write_reg(dbprr_pkg::RegPartitionCount, 32'd2);
    write_reg(dbprr_pkg::RegPartitionNumber, 32'd0);
    repeat (4) offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'hFFFF, 1'b1);

    // Zero cost limit, zero count, slot beyond the count.
    drain_results();
    phases++;
    write_reg(dbprr_pkg::RegMaxBatchCost, 32'd0);
    write_reg(dbprr_pkg::RegPartitionCount, 32'd0);
    write_reg(dbprr_pkg::RegPartitionNumber, 32'd1023);
    write_reg(dbprr_pkg::RegAllowPartial, 32'd0);
    offer_sample(16'd0, 1'b0);
    offer_sample(16'd0, 1'b1);
    offer_sample(16'd1, 1'b1);

    // Largest cost limit and a count above the supported maximum.
    drain_results();
    phases++;
    write_reg(dbprr_pkg::RegMaxBatchCost, 32'hFFFF_FFFF);
    write_reg(dbprr_pkg::RegPartitionCount, 32'h7FF);
    offer_sample(16'hFFFF, 1'b0);
    offer_sample(16'd0, 1'b1);

    cost_now  = 32'hFFFF_FFFF;
    count_now = 11'h7FF;
    len_cap   = 65535;

    // Random phases; a phase may end mid-run so that settings change inside a run.
    while (samples_sent < TargetSamples) begin
      drain_results();
      phases++;
      steady = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          cost_now = 32'd0;
          len_cap  = 3;
        end else if (pick == 1) begin
          cost_now = 32'hFFFF_FFFF;
          len_cap  = 65535;
        end else if (pick == 2) begin
          cost_now = $urandom;
          len_cap  = 65535;
        end else begin
          case ($urandom_range(0, 4))
            0:       len_cap = 3;
            1:       len_cap = 15;
            2:       len_cap = 255;
            3:       len_cap = 4095;
            default: len_cap = 65535;
          endcase
          cost_now = len_cap * $urandom_range(1, 6) + $urandom_range(0, len_cap);
        end
        write_reg(dbprr_pkg::RegMaxBatchCost, cost_now);
      end

      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) count_now = 11'd0;
        else if (pick == 1) count_now = 11'd1024;
        else if (pick == 2) count_now = 11'h7FF;
        else count_now = 11'($urandom_range(1, 6));
        data = {21'b0, count_now};
        if ($urandom_range(0, 3) == 0) data = ($urandom & ~32'h7FF) | data;
        write_reg(dbprr_pkg::RegPartitionCount, data);
      end

      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          num_now = 10'($urandom_range(0, 1023));
        end else if (count_now > 1) begin
          num_now = 10'($urandom_range(0, (count_now > 1024) ? 1023 : count_now - 1));
        end else begin
          num_now = 10'd0;
        end
        data = {22'b0, num_now};
        if ($urandom_range(0, 3) == 0) data = ($urandom & ~32'h3FF) | data;
        write_reg(dbprr_pkg::RegPartitionNumber, data);
      end

      if ($urandom_range(0, 1) == 0) begin
        data = {31'b0, 1'($urandom_range(0, 1))};
        if ($urandom_range(0, 3) == 0) data = ($urandom & ~32'h1) | data;
        write_reg(dbprr_pkg::RegAllowPartial, data);
      end

      runs = $urandom_range(1, 4);
      for (int r = 0; r < runs; r++) begin
        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        cut = (r == runs - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < run_len; k++) begin
          // Mostly lengths that pack under the limit, with oversize and full-range noise.
          if ($urandom_range(0, 39) == 0) begin
            len = (cost_now < 32'd65535) ? 16'(cost_now + 32'd1) : 16'($urandom);
          end else if ($urandom_range(0, 19) == 0) begin
            len = 16'($urandom);
          end else begin
            len = 16'($urandom_range(0, len_cap));
          end
          offer_sample(len, (k == run_len - 1) && !cut);
        end
      end
    end

    // Let the last results arrive and watch a little longer for stray ones.
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d samples over %0d setting phases with %0d register writes.",
             samples_sent, phases, reg_writes);
    $display("Checked %0d results: %0d batches, %0d oversize errors, %0d done items.",
             checked_cnt, batch_cnt, error_cnt, done_cnt);
    if (mismatches == 0 && pending_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
